// ===== src/dscb_pkg.sv =====
// shared constants, types and constant functions of the crystal ball evaluator
package dscb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int SPREAD_W  = 31;
    localparam int POWER_W   = 24;
    localparam int MAG_W     = DATA_W + 1;
    localparam int DVD_W     = MAG_W + FRAC_BITS;
    localparam int GARG_W    = 5 + FRAC_BITS;
    localparam int LOG_W     = 81;
    localparam int LOG_IW    = 7;
    localparam int LOG_OW    = LOG_IW + 32;
    localparam int CFG_IDX_W = 3;
    localparam logic [20:0] LOG2E_FRAC = 21'd1856798;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER      = 3'd0,
        CFG_SPREAD      = 3'd1,
        CFG_LEFT_CUT    = 3'd2,
        CFG_LEFT_POWER  = 3'd3,
        CFG_RIGHT_CUT   = 3'd4,
        CFG_RIGHT_POWER = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REGION_CORE  = 2'd0,
        REGION_LEFT  = 2'd1,
        REGION_RIGHT = 2'd2
    } t_region;

    // truncated integer square root, elaboration only
    function automatic logic [63:0] isqrt_c(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bt;
        logic [63:0] rem;
        res = '0;
        bt  = 64'd1 << 62;
        rem = v;
        while (bt > rem) bt = bt >> 2;
        while (bt != 0) begin
            if (rem >= res + bt) begin
                rem = rem - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // 2^(-2^(idx-32)) in Q1.31, built from 0.5 by repeated square roots
    function automatic logic [31:0] exp2_root(int idx);
        logic [63:0] c;
        c = 64'd1 << 30;
        for (int k = 31; k >= idx; k--) c = isqrt_c(c << 31);
        return c[31:0];
    endfunction

endpackage

// ===== src/dscb_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module dscb_div import dscb_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic [DVD_W-1:0]    i_dividend,
    input  logic [SPREAD_W-1:0] i_divisor,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_vld,
    output logic [DVD_W-1:0]    o_quot,
    output logic [SIDE_W-1:0]   o_side
);

    logic                r_vld  [DVD_W];
    logic [SPREAD_W-1:0] r_rem  [DVD_W];
    logic [DVD_W-1:0]    r_dvd  [DVD_W];
    logic [DVD_W-1:0]    r_quot [DVD_W];
    logic [SPREAD_W-1:0] r_dvs  [DVD_W];
    logic [SIDE_W-1:0]   r_side [DVD_W];

    for (genvar s = 0; s < DVD_W; s++) begin : g_stage
        logic                p_vld;
        logic [SPREAD_W-1:0] p_rem;
        logic [DVD_W-1:0]    p_dvd;
        logic [DVD_W-1:0]    p_quot;
        logic [SPREAD_W-1:0] p_dvs;
        logic [SIDE_W-1:0]   p_side;
        logic [SPREAD_W:0]   trial;
        logic                ge;

        if (s == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rem  = '0;
            assign p_dvd  = i_dividend;
            assign p_quot = '0;
            assign p_dvs  = i_divisor;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[s-1];
            assign p_rem  = r_rem[s-1];
            assign p_dvd  = r_dvd[s-1];
            assign p_quot = r_quot[s-1];
            assign p_dvs  = r_dvs[s-1];
            assign p_side = r_side[s-1];
        end

        assign trial = {p_rem, p_dvd[DVD_W-1]};
        assign ge    = trial >= {1'b0, p_dvs};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= ge ? SPREAD_W'(trial - {1'b0, p_dvs}) : trial[SPREAD_W-1:0];
            r_dvd[s]  <= {p_dvd[DVD_W-2:0], 1'b0};
            r_quot[s] <= {p_quot[DVD_W-2:0], ge};
            r_dvs[s]  <= p_dvs;
            r_side[s] <= p_side;
        end
    end

    assign o_vld  = r_vld[DVD_W-1];
    assign o_quot = r_quot[DVD_W-1];
    assign o_side = r_side[DVD_W-1];

endmodule

// ===== src/dscb_log2.sv =====
// pipelined base-2 logarithm, Q7.32 out, one fraction bit per stage by squaring
module dscb_log2 import dscb_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [LOG_W-1:0]  i_x,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [LOG_OW-1:0] o_log,
    output logic [SIDE_W-1:0] o_side
);

    localparam int SQ_N = 32;

    logic [LOG_IW-1:0] msb;
    logic              r0_vld;
    logic [LOG_W-1:0]  r0_x;
    logic [LOG_IW-1:0] r0_k;
    logic [SIDE_W-1:0] r0_side;
    logic [LOG_W-1:0]  norm;
    logic              r1_vld;
    logic [31:0]       r1_m;
    logic [LOG_IW-1:0] r1_k;
    logic [SIDE_W-1:0] r1_side;

    // leading one position
    always_comb begin
        msb = '0;
        for (int b = 0; b < LOG_W; b++) begin
            if (i_x[b]) msb = LOG_IW'(b);
        end
    end

    // top 32 bits with the leading one at bit 31
    always_comb begin
        if (r0_k >= LOG_IW'(31)) begin
            norm = r0_x >> (r0_k - LOG_IW'(31));
        end else begin
            norm = r0_x << (LOG_IW'(31) - r0_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
        end else begin
            r0_vld <= i_vld;
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_x    <= i_x;
        r0_k    <= msb;
        r0_side <= i_side;
        r1_m    <= norm[31:0];
        r1_k    <= r0_k;
        r1_side <= r0_side;
    end

    logic              r_vld  [SQ_N];
    logic [31:0]       r_m    [SQ_N];
    logic [31:0]       r_fr   [SQ_N];
    logic [LOG_IW-1:0] r_k    [SQ_N];
    logic [SIDE_W-1:0] r_side [SQ_N];

    for (genvar s = 0; s < SQ_N; s++) begin : g_sq
        logic              p_vld;
        logic [31:0]       p_m;
        logic [31:0]       p_fr;
        logic [LOG_IW-1:0] p_k;
        logic [SIDE_W-1:0] p_side;
        logic [63:0]       prod;
        logic [32:0]       sq;

        if (s == 0) begin : g_first
            assign p_vld  = r1_vld;
            assign p_m    = r1_m;
            assign p_fr   = '0;
            assign p_k    = r1_k;
            assign p_side = r1_side;
        end else begin : g_next
            assign p_vld  = r_vld[s-1];
            assign p_m    = r_m[s-1];
            assign p_fr   = r_fr[s-1];
            assign p_k    = r_k[s-1];
            assign p_side = r_side[s-1];
        end

        assign prod = 64'(p_m) * 64'(p_m);
        assign sq   = prod[63:31];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_m[s]    <= sq[32] ? sq[32:1] : sq[31:0];
            r_fr[s]   <= {p_fr[30:0], sq[32]};
            r_k[s]    <= p_k;
            r_side[s] <= p_side;
        end
    end

    assign o_vld  = r_vld[SQ_N-1];
    assign o_log  = {r_k[SQ_N-1], r_fr[SQ_N-1]};
    assign o_side = r_side[SQ_N-1];

endmodule

// ===== src/dscb_exp2.sv =====
// pipelined 2^-L, one fraction bit per stage, then the integer shift
module dscb_exp2 import dscb_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [31:0]       i_frac,
    input  logic [4:0]        i_shift,
    input  logic              i_zero,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [31:0]       o_value,
    output logic [SIDE_W-1:0] o_side
);

    localparam int NS = 32;

    logic              r_vld  [NS];
    logic [31:0]       r_m    [NS];
    logic [31:0]       r_f    [NS];
    logic [4:0]        r_sh   [NS];
    logic              r_z    [NS];
    logic [SIDE_W-1:0] r_side [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam logic [31:0] ROOT = exp2_root(31 - s);
        logic              p_vld;
        logic [31:0]       p_m;
        logic [31:0]       p_f;
        logic [4:0]        p_sh;
        logic              p_z;
        logic [SIDE_W-1:0] p_side;
        logic [63:0]       prod;

        if (s == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_m    = 32'h8000_0000;
            assign p_f    = i_frac;
            assign p_sh   = i_shift;
            assign p_z    = i_zero;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[s-1];
            assign p_m    = r_m[s-1];
            assign p_f    = r_f[s-1];
            assign p_sh   = r_sh[s-1];
            assign p_z    = r_z[s-1];
            assign p_side = r_side[s-1];
        end

        assign prod = 64'(p_m) * 64'(ROOT);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_m[s]    <= p_f[31-s] ? prod[62:31] : p_m;
            r_f[s]    <= p_f;
            r_sh[s]   <= p_sh;
            r_z[s]    <= p_z;
            r_side[s] <= p_side;
        end
    end

    logic              r_out_vld;
    logic [31:0]       r_out;
    logic [SIDE_W-1:0] r_out_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= r_z[NS-1] ? 32'd0 : (r_m[NS-1] >> r_sh[NS-1]);
        r_out_side <= r_side[NS-1];
    end

    assign o_vld   = r_out_vld;
    assign o_value = r_out;
    assign o_side  = r_out_side;

endmodule

// ===== src/double_sided_crystal_ball_eval.sv =====
// top level of the double-sided crystal ball density evaluator
//
// One sample per clock, start is taken in every cycle (busy stays low) and each
// result is on the outputs for exactly one cycle under o_strobe; the receiver
// cannot stall, so nothing is buffered. The path holds 124 register stages, the
// first loaded at the accepting edge: the 49-stage divider for (x - center) /
// spread, two 34-stage logarithm units working side by side for the power-law
// tail, and the 33-stage 2^-L unit; the rest is eight stages of multiplies
// and adds. All arithmetic is exact integer work in Q16.16 in and Q1.31 out
// (2^31 is 1.0). Configuration writes go straight into the registers
// (o_cfg_ready is always high) and must only happen while no sample is in
// flight; unknown register indexes are dropped.
module double_sided_crystal_ball_eval import dscb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [DATA_W-1:0]    i_sample,
    output logic                 o_strobe,
    output logic [DATA_W-1:0]    o_density,
    output logic [1:0]           o_region,
    output logic                 o_invalid,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    localparam int SIDE1_W = 1 + DATA_W + POWER_W;
    localparam int GW      = 42;
    localparam int LSIDE_W = GW + 2 + 1 + 1;

    // configuration registers
    logic [DATA_W-1:0]   r_center;
    logic [SPREAD_W-1:0] r_spread;
    logic [DATA_W-1:0]   r_lcut;
    logic [POWER_W-1:0]  r_lpow;
    logic [DATA_W-1:0]   r_rcut;
    logic [POWER_W-1:0]  r_rpow;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_spread <= SPREAD_W'(65536);
            r_lcut   <= DATA_W'(98304);
            r_lpow   <= POWER_W'(131072);
            r_rcut   <= DATA_W'(98304);
            r_rpow   <= POWER_W'(131072);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CENTER:      r_center <= i_cfg_data;
                CFG_SPREAD:      r_spread <= i_cfg_data[SPREAD_W-1:0];
                CFG_LEFT_CUT:    r_lcut   <= i_cfg_data;
                CFG_LEFT_POWER:  r_lpow   <= i_cfg_data[POWER_W-1:0];
                CFG_RIGHT_CUT:   r_rcut   <= i_cfg_data;
                CFG_RIGHT_POWER: r_rpow   <= i_cfg_data[POWER_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: distance from the center, side, and that side's tail setup
    logic signed [MAG_W-1:0] diff;
    logic                    s0_left;
    logic [DATA_W-1:0]       lcut_mag;
    logic [DATA_W-1:0]       rcut_mag;

    assign diff     = $signed({i_sample[DATA_W-1], i_sample})
                    - $signed({r_center[DATA_W-1], r_center});
    assign s0_left  = diff[MAG_W-1];
    assign lcut_mag = r_lcut[DATA_W-1] ? DATA_W'(-r_lcut) : r_lcut;
    assign rcut_mag = r_rcut[DATA_W-1] ? DATA_W'(-r_rcut) : r_rcut;

    logic                r1_vld;
    logic [MAG_W-1:0]    r1_mag;
    logic [SPREAD_W-1:0] r1_sp;
    logic                r1_left;
    logic [DATA_W-1:0]   r1_a;
    logic [POWER_W-1:0]  r1_n;

    always_ff @(posedge i_clk) begin
        r1_mag  <= s0_left ? MAG_W'(-diff) : MAG_W'(diff);
        // zero spread counts as one lsb
        r1_sp   <= (r_spread == '0) ? SPREAD_W'(1) : r_spread;
        r1_left <= s0_left;
        r1_a    <= s0_left ? lcut_mag : rcut_mag;
        r1_n    <= s0_left ? r_lpow : r_rpow;
    end

    // t = |x - center| / spread
    logic               dv_vld;
    logic [DVD_W-1:0]   dv_t;
    logic [SIDE1_W-1:0] dv_side;

    dscb_div #(.SIDE_W(SIDE1_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r1_vld),
        .i_dividend ({r1_mag, FRAC_BITS'(0)}),
        .i_divisor  (r1_sp),
        .i_side     ({r1_left, r1_a, r1_n}),
        .o_vld      (dv_vld),
        .o_quot     (dv_t),
        .o_side     (dv_side)
    );

    logic               dv_left;
    logic [DATA_W-1:0]  dv_a;
    logic [POWER_W-1:0] dv_n;
    logic [DVD_W-1:0]   dv_a_w;
    logic               dv_core;
    logic [DVD_W-1:0]   dv_v;

    assign {dv_left, dv_a, dv_n} = dv_side;
    assign dv_a_w  = DVD_W'(dv_a);
    assign dv_core = dv_t <= dv_a_w;
    // the core uses t itself, a tail starts from its cut
    assign dv_v    = dv_core ? dv_t : dv_a_w;

    // stage 2: region decision
    logic               r2_vld;
    logic [GARG_W-1:0]  r2_v;
    logic               r2_gsat;
    logic [DVD_W-1:0]   r2_d;
    logic [DATA_W-1:0]  r2_a;
    logic [POWER_W-1:0] r2_n;
    t_region            r2_region;
    logic               r2_inval;
    logic               r2_tail;

    always_ff @(posedge i_clk) begin
        r2_v      <= dv_v[GARG_W-1:0];
        r2_gsat   <= |dv_v[DVD_W-1:GARG_W];
        r2_d      <= dv_t - dv_a_w;
        r2_a      <= dv_a;
        r2_n      <= dv_n;
        r2_region <= dv_core ? REGION_CORE : (dv_left ? REGION_LEFT : REGION_RIGHT);
        r2_inval  <= !dv_core && (dv_a == '0);
        r2_tail   <= !dv_core && (dv_a != '0) && (dv_n != '0);
    end

    // stage 3: square of the gaussian argument, partial products of a*(t-a)
    localparam int DLO_W = 24;
    localparam int DHI_W = DVD_W - DLO_W;
    localparam int XW    = 2 * GARG_W - 1;

    logic [2*GARG_W-1:0] sq;
    assign sq = (2*GARG_W)'(r2_v) * (2*GARG_W)'(r2_v);

    logic                      r3_vld;
    logic [XW-1:0]             r3_x;
    logic [DATA_W+DLO_W-1:0]   r3_pl;
    logic [DATA_W+DHI_W-1:0]   r3_ph;
    logic                      r3_gsat;
    logic [POWER_W-1:0]        r3_n;
    t_region                   r3_region;
    logic                      r3_inval;
    logic                      r3_tail;

    always_ff @(posedge i_clk) begin
        r3_x      <= sq[2*GARG_W-1:1];
        r3_pl     <= (DATA_W+DLO_W)'(r2_a) * (DATA_W+DLO_W)'(r2_d[DLO_W-1:0]);
        r3_ph     <= (DATA_W+DHI_W)'(r2_a) * (DATA_W+DHI_W)'(r2_d[DVD_W-1:DLO_W]);
        r3_gsat   <= r2_gsat;
        r3_n      <= r2_n;
        r3_region <= r2_region;
        r3_inval  <= r2_inval;
        r3_tail   <= r2_tail;
    end

    // stage 4: log2(e) scaling product, tail denominator n*2^F + a*(t-a)
    localparam int XMW = XW + 21;

    logic               r4_vld;
    logic [XW-1:0]      r4_x;
    logic [XMW-1:0]     r4_xm;
    logic [LOG_W-1:0]   r4_big;
    logic               r4_gsat;
    logic [POWER_W-1:0] r4_n;
    t_region            r4_region;
    logic               r4_inval;
    logic               r4_tail;

    always_ff @(posedge i_clk) begin
        r4_x      <= r3_x;
        r4_xm     <= XMW'(r3_x) * XMW'(LOG2E_FRAC);
        r4_big    <= LOG_W'(r3_pl) + {r3_ph, DLO_W'(0)}
                   + LOG_W'({r3_n, FRAC_BITS'(0)});
        r4_gsat   <= r3_gsat;
        r4_n      <= r3_n;
        r4_region <= r3_region;
        r4_inval  <= r3_inval;
        r4_tail   <= r3_tail;
    end

    // stage 5: exponent of the gaussian part in Q.32, 64.0 when the argument is huge
    logic               r5_vld;
    logic [GW-1:0]      r5_g;
    logic [LOG_W-1:0]   r5_big;
    logic [LOG_W-1:0]   r5_num;
    logic [POWER_W-1:0] r5_n;
    t_region            r5_region;
    logic               r5_inval;
    logic               r5_tail;

    always_ff @(posedge i_clk) begin
        r5_g      <= r4_gsat ? (GW'(64) << 32) : (GW'(r4_x) + GW'(r4_xm[XMW-1:22]));
        r5_big    <= r4_big;
        r5_num    <= LOG_W'({r4_n, FRAC_BITS'(0)});
        r5_n      <= r4_n;
        r5_region <= r4_region;
        r5_inval  <= r4_inval;
        r5_tail   <= r4_tail;
    end

    // log2 of both sides of the tail ratio
    logic               la_vld;
    logic [LOG_OW-1:0]  la_log;
    logic [LSIDE_W-1:0] la_side;
    logic               lb_vld;
    logic [LOG_OW-1:0]  lb_log;
    logic [POWER_W-1:0] lb_side;

    dscb_log2 #(.SIDE_W(LSIDE_W)) u_log_den (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r5_vld),
        .i_x     (r5_big),
        .i_side  ({r5_g, r5_region, r5_inval, r5_tail}),
        .o_vld   (la_vld),
        .o_log   (la_log),
        .o_side  (la_side)
    );

    dscb_log2 #(.SIDE_W(POWER_W)) u_log_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r5_vld),
        .i_x     (r5_num),
        .i_side  (r5_n),
        .o_vld   (lb_vld),
        .o_log   (lb_log),
        .o_side  (lb_side)
    );

    // stage 6: log ratio clamped at zero
    logic               r6_vld;
    logic [LOG_OW-1:0]  r6_dl;
    logic [LSIDE_W-1:0] r6_side;
    logic [POWER_W-1:0] r6_n;

    always_ff @(posedge i_clk) begin
        r6_dl   <= (la_log > lb_log) ? (la_log - lb_log) : '0;
        r6_side <= la_side;
        r6_n    <= lb_side;
    end

    // stage 7: n * log ratio
    localparam int PW = POWER_W + LOG_OW;

    logic               r7_vld;
    logic [PW-1:0]      r7_p;
    logic [LSIDE_W-1:0] r7_side;

    always_ff @(posedge i_clk) begin
        r7_p    <= PW'(r6_n) * PW'(r6_dl);
        r7_side <= r6_side;
    end

    // stage 8: total exponent, split into shift and fraction
    localparam int LW = PW - FRAC_BITS + 1;

    logic [GW-1:0] s7_g;
    t_region       s7_region;
    logic          s7_inval;
    logic          s7_tail;
    logic [LW-1:0] s7_l;

    assign {s7_g, s7_region, s7_inval, s7_tail} = r7_side;
    assign s7_l = LW'(s7_g) + (s7_tail ? LW'(r7_p[PW-1:FRAC_BITS]) : LW'(0));

    logic        r8_vld;
    logic [31:0] r8_frac;
    logic [4:0]  r8_shift;
    logic        r8_zero;
    logic [2:0]  r8_side;

    always_ff @(posedge i_clk) begin
        r8_frac  <= s7_l[31:0];
        r8_shift <= s7_l[36:32];
        // invalid cut or an integer exponent of 32 and more gives zero
        r8_zero  <= s7_inval || (|s7_l[LW-1:37]);
        r8_side  <= {s7_region, s7_inval};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
        end else begin
            r1_vld <= start && !busy;
            r2_vld <= dv_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= la_vld && lb_vld;
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
        end
    end

    logic [2:0] ex_side;

    dscb_exp2 #(.SIDE_W(3)) u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r8_vld),
        .i_frac  (r8_frac),
        .i_shift (r8_shift),
        .i_zero  (r8_zero),
        .i_side  (r8_side),
        .o_vld   (o_strobe),
        .o_value (o_density),
        .o_side  (ex_side)
    );

    assign o_region  = ex_side[2:1];
    assign o_invalid = ex_side[0];

    // the core never flags an invalid cut
    a_core_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_region == REGION_CORE) |-> !o_invalid)
        else $error("core result flagged invalid");

    // an invalid tail always reads as zero density
    a_inval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_invalid |-> (o_density == '0))
        else $error("invalid tail with nonzero density");

    // density never passes 1.0
    a_dens_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_density <= 32'h8000_0000))
        else $error("density above one");

    // both logarithm lanes stay in step
    a_log_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        la_vld == lb_vld)
        else $error("logarithm lanes out of step");

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench of the double-sided crystal ball evaluator
module testbench;
    import dscb_pkg::*;

    localparam int  HALF_PERIOD  = 10;
    localparam int  RESET_CYCLES = 10;
    // result latency from the top level, plus margin
    localparam int  DRAIN_CYCLES = 140;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  RANDOM_ITEMS = 2000;
    localparam int  REPORT_MAX   = 10;
    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
    localparam logic [63:0] ONE_Q31 = 64'd1 << 31;

    typedef struct packed {
        logic [DATA_W-1:0] density;
        logic [1:0]        region;
        logic              invalid;
    } density_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [DATA_W-1:0]    i_sample = '0;
    logic                 o_strobe;
    logic [DATA_W-1:0]    o_density;
    logic [1:0]           o_region;
    logic                 o_invalid;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0]    i_cfg_data = '0;

    // shadow copy of the configuration registers
    logic [31:0] m_center;
    logic [30:0] m_spread;
    logic [31:0] m_left_cut;
    logic [23:0] m_left_power;
    logic [31:0] m_right_cut;
    logic [23:0] m_right_power;

    density_t pending_density_q[$];
    int       mismatches = 0;
    int       cycles = 0;
    bit       gaps_on = 1'b0;

    double_sided_crystal_ball_eval i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_sample    (i_sample),
        .o_strobe    (o_strobe),
        .o_density   (o_density),
        .o_region    (o_region),
        .o_invalid   (o_invalid),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // ---------------- density predictor ----------------

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bt;
        res = '0;
        bt  = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // log2 in Q32.32 of a nonzero 64 bit value
    function automatic logic [63:0] log2_q32(logic [63:0] v);
        int          k;
        logic [63:0] m;
        logic [63:0] fr;
        k = 63;
        while (!v[k]) k--;
        m  = (k >= 31) ? (v >> (k - 31)) : (v << (31 - k));
        fr = '0;
        for (int i = 0; i < 32; i++) begin
            m  = (m * m) >> 31;
            fr = fr << 1;
            if (m >= (64'd1 << 32)) begin
                fr[0] = 1'b1;
                m     = m >> 1;
            end
        end
        return (64'(k) << 32) | fr;
    endfunction

    // wide argument is squeezed into 64 bits and the shift added back
    function automatic logic [63:0] log2_wide(logic [127:0] v);
        int          p;
        logic [63:0] sh;
        if (v[127:64] == 0) return log2_q32(v[63:0]);
        p = 63;
        while (!v[64+p]) p--;
        sh = 64'(v >> (p + 1));
        return log2_q32(sh) + (64'(p + 1) << 32);
    endfunction

    // v*v/2*log2(e) in Q32.32
    function automatic logic [63:0] gauss_exponent(logic [63:0] v);
        logic [63:0] x;
        if (v >= (64'd32 << FRAC_BITS)) return 64'd64 << 32;
        x = (v * v) >> 1;
        return x + ((x * 64'(LOG2E_FRAC)) >> 22);
    endfunction

    // 2^-L with 2^31 as one
    function automatic logic [63:0] exp2_neg(logic [63:0] lq);
        logic [63:0] m;
        logic [63:0] c;
        if ((lq >> 32) >= 32) return '0;
        m = ONE_Q31;
        c = 64'd1 << 30;
        for (int i = 31; i >= 0; i--) begin
            c = floor_sqrt(c << 31);
            if (lq[i]) m = (m * c) >> 31;
        end
        return m >> (lq >> 32);
    endfunction

    function automatic logic [63:0] power_tail(logic [63:0] a, logic [63:0] n,
                                               logic [63:0] tm);
        logic [63:0]  lq;
        logic [63:0]  num;
        logic [127:0] den;
        logic [63:0]  ln;
        logic [63:0]  lden;
        logic [63:0]  dlog;
        lq = gauss_exponent(a);
        if (n != 0) begin
            num  = n << FRAC_BITS;
            den  = 128'(a) * 128'(tm - a) + 128'(num);
            ln   = log2_q32(num);
            lden = log2_wide(den);
            dlog = (lden > ln) ? lden - ln : '0;
            lq   = lq + ((n * dlog) >> FRAC_BITS);
        end
        return exp2_neg(lq);
    endfunction

    function automatic logic [63:0] cut_magnitude(logic [31:0] c);
        return c[31] ? 64'(-$signed({32'hFFFF_FFFF, c})) : 64'(c);
    endfunction

    function automatic density_t predict_density(logic [31:0] sample);
        density_t    r;
        longint      diff;
        logic        left;
        logic [63:0] mag;
        logic [63:0] tm;
        logic [63:0] a;
        logic [63:0] n;
        logic [63:0] dens;
        diff = longint'($signed(sample)) - longint'($signed(m_center));
        left = diff < 0;
        mag  = left ? 64'(-diff) : 64'(diff);
        // zero spread acts as one lsb
        tm   = (mag << FRAC_BITS) / ((m_spread == 0) ? 64'd1 : 64'(m_spread));
        a    = left ? cut_magnitude(m_left_cut) : cut_magnitude(m_right_cut);
        n    = left ? 64'(m_left_power) : 64'(m_right_power);
        r.region  = REGION_CORE;
        r.invalid = 1'b0;
        if (tm <= a) begin
            dens = exp2_neg(gauss_exponent(tm));
        end else begin
            r.region = left ? REGION_LEFT : REGION_RIGHT;
            if (a == 0) begin
                r.invalid = 1'b1;
                dens      = '0;
            end else begin
                dens = power_tail(a, n, tm);
            end
        end
        if (dens > ONE_Q31) dens = ONE_Q31;
        r.density = dens[31:0];
        return r;
    endfunction

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin
        density_t want;
        if (i_rst_n && o_strobe) begin
            if (pending_density_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result density=%h region=%0d invalid=%b",
                             o_density, o_region, o_invalid);
            end else begin
                want = pending_density_q.pop_front();
                if (o_density !== want.density || o_region !== want.region
                        || o_invalid !== want.invalid) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: exp density=%h region=%0d invalid=%b, got %h %0d %b",
                                 want.density, want.region, want.invalid,
                                 o_density, o_region, o_invalid);
                end
            end
        end
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------- drivers ----------------

    // one sample transfer, expectation taken at the accepting edge
    task automatic send_sample(logic [31:0] s);
        start    <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (busy);
        pending_density_q.push_back(predict_density(s));
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // every sample makes one result, so an empty queue means the pipe is empty
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_density_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_CENTER:      m_center      = data;
            CFG_SPREAD:      m_spread      = data[30:0];
            CFG_LEFT_CUT:    m_left_cut    = data;
            CFG_LEFT_POWER:  m_left_power  = data[23:0];
            CFG_RIGHT_CUT:   m_right_cut   = data;
            CFG_RIGHT_POWER: m_right_power = data[23:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(logic [31:0] c, logic [31:0] sp, logic [31:0] lc,
                             logic [31:0] lp, logic [31:0] rc, logic [31:0] rp);
        wait_idle();
        write_reg(CFG_CENTER, c);
        write_reg(CFG_SPREAD, sp);
        write_reg(CFG_LEFT_CUT, lc);
        write_reg(CFG_LEFT_POWER, lp);
        write_reg(CFG_RIGHT_CUT, rc);
        write_reg(CFG_RIGHT_POWER, rp);
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_values();
        // core, both cut edges, tails and the input extremes
        send_sample(32'h0000_0000);
        send_sample(32'h0001_0000);
        send_sample(32'hFFFE_8000);
        send_sample(32'h0001_8000);
        send_sample(32'h0001_8001);
        send_sample(32'hFFFD_0000);
        send_sample(32'h0005_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
    endtask

    task automatic test_special_cases();
        // zero left cut flags invalid, zero right power gives a flat tail
        write_all(32'h0, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0001_0000, 32'h0);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0000);
        send_sample(32'h0003_0000);
        send_sample(32'h7FFF_FFFF);
        // zero spread, most negative cuts, largest powers
        write_all(32'h0, 32'h0, 32'h8000_0000, 32'hFF_FFFF, 32'h8000_0000, 32'hFF_FFFF);
        send_sample(32'h0000_0001);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h8000_0000);
        // extreme center, largest spread, one-lsb powers
        write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h1,
                  32'h7FFF_FFFF, 32'h1);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        write_all(32'h8000_0000, 32'h1, 32'h0000_0001, 32'h0001_0000,
                  32'h0000_0001, 32'h0080_0000);
        send_sample(32'h8000_0000);
        send_sample(32'h8000_0001);
        send_sample(32'h8000_0002);
        send_sample(32'h7FFF_FFFF);
        // unknown indexes are dropped
        wait_idle();
        write_reg(CFG_UNUSED_LO, $urandom());
        write_reg(CFG_UNUSED_HI, $urandom());
        send_sample(32'h8000_0003);
    endtask

    function automatic logic [31:0] pick_cut();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return $urandom();
            default: return $urandom_range(0, 32'h0004_0000) * ($urandom_range(0, 1) ? 1 : -1);
        endcase
    endfunction

    function automatic logic [31:0] pick_power();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFF_FFFF;
            2: return $urandom() & 32'hFF_FFFF;
            default: return $urandom_range(1, 32'h0010_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_spread();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'h1;
            2: return 32'h7FFF_FFFF;
            3: return $urandom();
            default: return $urandom_range(32'h0000_0400, 32'h0010_0000);
        endcase
    endfunction

    task automatic test_random_mix();
        int          phases;
        int          per_phase;
        logic [63:0] off;
        phases    = 20;
        per_phase = RANDOM_ITEMS / phases;
        for (int p = 0; p < phases; p++) begin
            write_all($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0010_0000),
                      pick_spread(), pick_cut(), pick_power(), pick_cut(), pick_power());
            // last phases run back to back
            gaps_on = (p < phases - 3) && ($urandom_range(0, 4) != 0);
            for (int i = 0; i < per_phase; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_sample($urandom());
                end else begin
                    // a few spreads either side of the center reaches core and tails
                    off = 64'(m_spread) * $urandom_range(0, 8) + $urandom_range(0, 32'hFFFF);
                    send_sample($urandom_range(0, 1) ? m_center + off[31:0]
                                                     : m_center - off[31:0]);
                end
            end
        end
    endtask

    initial begin
        m_center      = 32'h0;
        m_spread      = 31'h0001_0000;
        m_left_cut    = 32'h0001_8000;
        m_left_power  = 24'h02_0000;
        m_right_cut   = 32'h0001_8000;
        m_right_power = 24'h02_0000;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_special_cases();
        test_random_mix();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_density_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
